// ===== rtl/core/sha1_pkg.sv =====
// shared types, round constants and initial chaining values of the sha-1 engine
package sha1_pkg;

    // round constants
    localparam logic [31:0] K_R0 = 32'h5A827999;
    localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_R3 = 32'hCA62C1D6;

    // initial chaining values
    localparam logic [31:0] H_INIT0 = 32'h67452301;
    localparam logic [31:0] H_INIT1 = 32'hEFCDAB89;
    localparam logic [31:0] H_INIT2 = 32'h98BADCFE;
    localparam logic [31:0] H_INIT3 = 32'h10325476;
    localparam logic [31:0] H_INIT4 = 32'hC3D2E1F0;

    // padding marker byte
    localparam logic [7:0] PAD_BYTE = 8'h80;

    // geometry
    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned ROUNDS      = 80;
    localparam int unsigned CHAIN_WORDS = 5;

    typedef logic [31:0] t_word;
    typedef logic [CHAIN_WORDS-1:0][31:0] t_chain;

    // control from the sequencer to the schedule and round datapath
    typedef struct packed {
        logic       load;   // copy chaining words into the working registers
        logic       step;   // run one round
        logic       add;    // fold working registers into the chaining words
        logic       init;   // return chaining words to their initial values
        logic [6:0] rnd;    // current round number
    } t_rnd_ctl;

endpackage

// ===== rtl/core/sha1_if.sv =====
// item channels of the sha-1 engine: byte input and digest word output
interface sha1_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] data_byte;

    modport source (output valid, output mode, output data_byte, input ready);
    modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface sha1_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

// ===== rtl/core/sha1_hash_engine.sv =====
// sha-1 engine top level: byte buffering, padding, sequencing and digest output
//
// Streaming SHA-1. A mode-0 item absorbs one message byte; bytes are packed
// into words and written to a 16 x 32 block ram. Each 64th byte starts a
// compression (a ram prime step, 80 rounds at one round per cycle, a chaining
// add) during which no item is accepted. A mode-1 item finalizes: the rest of
// the block is padded at one ram word per cycle (16 minus the buffered word
// count), then compressed; with 56 or more bytes buffered a second padded
// block of 16 writes and another compression follows. The five digest words
// then leave through an output register, one per cycle while the sink takes
// them, H0 first, and the engine is ready for a new message. The round loop,
// fed from the block ram and a sixteen-word schedule window, sets the
// throughput.
module sha1_hash_engine import sha1_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sha1_in_if.sink           i_in,
    sha1_out_if.source        o_out
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PAD   = 6'b000010,
        ST_PRIME = 6'b000100,
        ST_ROUND = 6'b001000,
        ST_ADD   = 6'b010000,
        ST_EMIT  = 6'b100000
    } t_state;

    t_state      r_state, n_state;
    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    logic [23:0] r_acc;
    logic        r_fin, r_extra, r_pad_first;
    logic [3:0]  r_pad_idx;
    logic [6:0]  r_rnd;
    logic [2:0]  r_emit_idx;
    logic        r_ov;
    t_word       r_out_word;
    logic [2:0]  r_out_idx;
    logic        r_out_last;

    logic        w_in_acc, w_absorb, w_final, w_emit_go;
    logic        w_ram_we;
    logic [3:0]  w_ram_waddr, w_ram_raddr;
    t_word       w_ram_wdata, w_ram_rdata, w_pad_word, w_pad_data, w_w;
    t_chain      w_chain;
    t_rnd_ctl    w_ctl;

    // input handshake
    assign i_in.ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_absorb   = w_in_acc && !i_in.mode;
    assign w_final    = w_in_acc && i_in.mode;
    assign w_emit_go  = (r_state == ST_EMIT) && (!r_ov || o_out.ready);

    // word holding the marker after the buffered bytes of a partial word
    always_comb begin
        case (r_fill[1:0])
            2'd0:    w_pad_word = {PAD_BYTE, 24'h0};
            2'd1:    w_pad_word = {r_acc[7:0], PAD_BYTE, 16'h0};
            2'd2:    w_pad_word = {r_acc[15:0], PAD_BYTE, 8'h0};
            default: w_pad_word = {r_acc[23:0], PAD_BYTE};
        endcase
    end

    // padding pass data: marker word, bit count in the last two words of the final block, else zero
    always_comb begin
        if (r_pad_first) begin
            w_pad_data = w_pad_word;
        end else if (!r_extra && r_pad_idx == 4'd14) begin
            w_pad_data = r_bits[63:32];
        end else if (!r_extra && r_pad_idx == 4'd15) begin
            w_pad_data = r_bits[31:0];
        end else begin
            w_pad_data = '0;
        end
    end

    // block ram access
    always_comb begin
        if (r_state == ST_PAD) begin
            w_ram_we    = 1'b1;
            w_ram_waddr = r_pad_idx;
            w_ram_wdata = w_pad_data;
        end else begin
            w_ram_we    = w_absorb && (r_fill[1:0] == 2'd3);
            w_ram_waddr = r_fill[5:2];
            w_ram_wdata = {r_acc, i_in.data_byte};
        end
        w_ram_raddr = (r_state == ST_PRIME) ? 4'd0 : (r_rnd[3:0] + 4'd1);
    end

    // datapath control
    always_comb begin
        w_ctl.load = (r_state == ST_PRIME);
        w_ctl.step = (r_state == ST_ROUND);
        w_ctl.add  = (r_state == ST_ADD);
        w_ctl.init = w_emit_go && (r_emit_idx == 3'd4);
        w_ctl.rnd  = r_rnd;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_final) begin
                    n_state = ST_PAD;
                end else if (w_absorb && r_fill == 6'd63) begin
                    n_state = ST_PRIME;
                end
            end
            ST_PAD: begin
                if (r_pad_idx == 4'd15) begin
                    n_state = ST_PRIME;
                end
            end
            ST_PRIME: n_state = ST_ROUND;
            ST_ROUND: begin
                if (r_rnd == 7'(ROUNDS - 1)) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                if (r_fin && r_extra) begin
                    n_state = ST_PAD;
                end else if (r_fin) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (w_ctl.init) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer and message bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_bits      <= '0;
            r_fin       <= 1'b0;
            r_extra     <= 1'b0;
            r_pad_first <= 1'b0;
            r_pad_idx   <= '0;
            r_rnd       <= '0;
            r_emit_idx  <= '0;
        end else begin
            r_state <= n_state;
            if (w_absorb) begin
                r_fill <= r_fill + 6'd1;
                r_bits <= r_bits + 64'd8;
            end
            if (w_final) begin
                r_fin       <= 1'b1;
                r_extra     <= (r_fill[5:3] == 3'b111);
                r_pad_first <= 1'b1;
                r_pad_idx   <= r_fill[5:2];
            end
            if (r_state == ST_PAD) begin
                r_pad_first <= 1'b0;
                r_pad_idx   <= r_pad_idx + 4'd1;
            end
            if (r_state == ST_PRIME) begin
                r_rnd <= '0;
            end
            if (r_state == ST_ROUND) begin
                r_rnd <= r_rnd + 7'd1;
            end
            if (r_state == ST_ADD) begin
                r_emit_idx <= '0;
                if (r_fin && r_extra) begin
                    r_extra   <= 1'b0;
                    r_pad_idx <= '0;
                end
            end
            if (w_emit_go) begin
                r_emit_idx <= r_emit_idx + 3'd1;
            end
            // fresh message once the last digest word is taken into the output
            if (w_ctl.init) begin
                r_fill <= '0;
                r_bits <= '0;
                r_fin  <= 1'b0;
            end
        end
    end

    // partial word assembly
    always_ff @(posedge i_clk) begin
        if (w_absorb) begin
            r_acc <= {r_acc[15:0], i_in.data_byte};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_emit_go) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit_go) begin
            r_out_word <= w_chain[r_emit_idx];
            r_out_idx  <= r_emit_idx;
            r_out_last <= (r_emit_idx == 3'd4);
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.digest_word = r_out_word;
    assign o_out.word_index  = r_out_idx;
    assign o_out.last_word   = r_out_last;

    // block buffer
    sha1_ram #(
        .WIDTH(32),
        .DEPTH(16)
    ) u_blk_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // message schedule
    sha1_sched u_sched (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_ram_word (w_ram_rdata),
        .o_w        (w_w)
    );

    // compression rounds and chaining words
    sha1_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_w     (w_w),
        .o_chain (w_chain)
    );

endmodule

// ===== rtl/core/sha1_ram.sv =====
// generic single-write single-read ram with registered read data
module sha1_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/sha1_sched.sv =====
// message schedule: sixteen-word sliding window fed from the block ram
module sha1_sched import sha1_pkg::*; (
    input  logic     i_clk,
    input  t_rnd_ctl i_ctl,
    input  t_word    i_ram_word,
    output t_word    o_w
);

    t_word r_win [BLOCK_WORDS];
    t_word w_mix;

    // expansion from the window, or the stored word in the first sixteen rounds
    always_comb begin
        w_mix = r_win[13] ^ r_win[8] ^ r_win[2] ^ r_win[0];
        if (i_ctl.rnd[6:4] == 3'd0) begin
            o_w = i_ram_word;
        end else begin
            o_w = {w_mix[30:0], w_mix[31]};
        end
    end

    // window shifts by one word per round
    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[BLOCK_WORDS-1] <= o_w;
        end
    end

endmodule

// ===== rtl/core/sha1_round.sv =====
// compression datapath: working registers, round function and chaining words
module sha1_round import sha1_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_rnd_ctl i_ctl,
    input  t_word    i_w,
    output t_chain   o_chain
);

    t_chain r_h;
    t_word  r_a, r_b, r_c, r_d, r_e;
    t_word  w_f, w_k, w_t;

    // round function and constant by round group
    always_comb begin
        if (i_ctl.rnd < 7'd20) begin
            w_f = (r_b & r_c) | (~r_b & r_d);
            w_k = K_R0;
        end else if (i_ctl.rnd < 7'd40) begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K_R1;
        end else if (i_ctl.rnd < 7'd60) begin
            w_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            w_k = K_R2;
        end else begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K_R3;
        end
        w_t = {r_a[26:0], r_a[31:27]} + w_f + r_e + w_k + i_w;
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (i_ctl.step) begin
            r_a <= w_t;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    // chaining words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.init) begin
            r_h <= {H_INIT4, H_INIT3, H_INIT2, H_INIT1, H_INIT0};
        end else if (i_ctl.add) begin
            r_h[0] <= r_h[0] + r_a;
            r_h[1] <= r_h[1] + r_b;
            r_h[2] <= r_h[2] + r_c;
            r_h[3] <= r_h[3] + r_d;
            r_h[4] <= r_h[4] + r_e;
        end
    end

    assign o_chain = r_h;

endmodule

// ===== rtl/core/sha1_checker.sv =====
// port-level checks of the sha-1 engine and their binding to the top level
module sha1_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_word,
    input logic [2:0]  i_out_idx,
    input logic        i_out_last
);

    // a stalled digest word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_word)
            && $stable(i_out_idx) && $stable(i_out_last))
        else $error("digest word dropped or changed while stalled");

    // last flag marks exactly the fifth word
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_last == (i_out_idx == 3'd4)))
        else $error("last_word does not match word_index");

    // digest words follow in order
    a_idx_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |=>
            !i_out_valid || (i_out_idx == $past(i_out_idx) + 3'd1))
        else $error("digest word out of order");

    // no new item is taken while a digest is only partly out
    a_busy_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("input ready while digest words remain");

    // reset empties the output
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind sha1_hash_engine sha1_checker u_sha1_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_word  (o_out.digest_word),
    .i_out_idx   (o_out.word_index),
    .i_out_last  (o_out.last_word)
);

// ===== sim/tb_sha1_hash_engine.sv =====
// self-checking testbench of the sha-1 engine: directed table, random messages, digest predictor
module tb_sha1_hash_engine import sha1_pkg::*; ();

    // item codes of the input channel
    localparam logic MODE_ABSORB = 1'b0;
    localparam logic MODE_FINISH = 1'b1;

    // digests that are known by heart
    localparam logic [159:0] EMPTY_DIGEST = 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709;
    localparam logic [159:0] ABC_DIGEST   = 160'ha9993e364706816aba3e25717850c26c9cd0d89d;

    // run length and limits
    localparam int unsigned TOTAL_ITEMS  = 430;
    localparam int unsigned CALM_FROM    = 370;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned QUIET_LIMIT  = 4000;
    localparam int unsigned DRAIN_CYCLES = 200;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest_word;

    typedef struct packed {
        logic         mode;
        logic [7:0]   data;
        logic         known;
        logic [159:0] digest;
    } t_stim_row;

    // directed stimulus, typed digest only where it is well known
    localparam int unsigned DIRECTED_COUNT = 14;
    localparam t_stim_row DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{MODE_FINISH, 8'h00, 1'b1, EMPTY_DIGEST},
        '{MODE_FINISH, 8'h00, 1'b1, EMPTY_DIGEST},
        '{MODE_ABSORB, 8'h61, 1'b0, 160'h0},
        '{MODE_ABSORB, 8'h62, 1'b0, 160'h0},
        '{MODE_ABSORB, 8'h63, 1'b0, 160'h0},
        '{MODE_FINISH, 8'h00, 1'b1, ABC_DIGEST},
        '{MODE_ABSORB, 8'h00, 1'b0, 160'h0},
        '{MODE_ABSORB, 8'hFF, 1'b0, 160'h0},
        '{MODE_FINISH, 8'h00, 1'b0, 160'h0},
        '{MODE_ABSORB, 8'h55, 1'b0, 160'h0},
        '{MODE_ABSORB, 8'hAA, 1'b0, 160'h0},
        '{MODE_ABSORB, 8'h00, 1'b0, 160'h0},
        '{MODE_FINISH, 8'hFF, 1'b0, 160'h0},
        '{MODE_FINISH, 8'hA5, 1'b1, EMPTY_DIGEST}
    };

    logic i_clk;
    logic i_rst_n;

    sha1_in_if  in_ch ();
    sha1_out_if out_ch ();

    sha1_hash_engine DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // hash state of the predictor
    logic [31:0]  h_chain [CHAIN_WORDS];
    logic [7:0]   msg_block [64];
    int unsigned  msg_fill;
    logic [63:0]  msg_bit_count;

    t_digest_word digest_q [$];
    int unsigned  mismatches;
    int unsigned  items_sent;
    int unsigned  idle_pct;
    int unsigned  stall_pct;
    bit           calm;
    bit           hold_req;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void restart_message();
        h_chain[0]    = H_INIT0;
        h_chain[1]    = H_INIT1;
        h_chain[2]    = H_INIT2;
        h_chain[3]    = H_INIT3;
        h_chain[4]    = H_INIT4;
        msg_fill      = 0;
        msg_bit_count = '0;
    endfunction

    // 80-round compression of msg_block into h_chain
    function automatic void compress_block();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int r = 0; r < 16; r++)
            w[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
        for (int r = 16; r < 80; r++) begin
            t    = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
            w[r] = {t[30:0], t[31]};
        end
        a = h_chain[0];
        b = h_chain[1];
        c = h_chain[2];
        d = h_chain[3];
        e = h_chain[4];
        for (int r = 0; r < 80; r++) begin
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = K_R0;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = K_R1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_R2;
            end else begin
                f = b ^ c ^ d;
                k = K_R3;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[r];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        h_chain[0] += a;
        h_chain[1] += b;
        h_chain[2] += c;
        h_chain[3] += d;
        h_chain[4] += e;
    endfunction

    // advance the hash state by one item; returns 1 with the digest on a finish
    function automatic bit predict_digest(input logic mode, input logic [7:0] data,
                                          output logic [159:0] digest);
        int unsigned pos;
        digest = '0;
        if (mode == MODE_ABSORB) begin
            msg_block[msg_fill] = data;
            msg_fill++;
            msg_bit_count += 64'd8;
            if (msg_fill == 64) begin
                compress_block();
                msg_fill = 0;
            end
            return 1'b0;
        end
        // padding, with an extra block when the length no longer fits
        msg_block[msg_fill] = PAD_BYTE;
        pos = msg_fill + 1;
        if (pos > 56) begin
            while (pos < 64) begin
                msg_block[pos] = 8'h00;
                pos++;
            end
            compress_block();
            pos = 0;
        end
        while (pos < 56) begin
            msg_block[pos] = 8'h00;
            pos++;
        end
        for (int i = 0; i < 8; i++)
            msg_block[56+i] = msg_bit_count[63-8*i -: 8];
        compress_block();
        for (int i = 0; i < CHAIN_WORDS; i++)
            digest[159-32*i -: 32] = h_chain[i];
        restart_message();
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    // offer one item from a falling edge, wait for the handshake, record the expectation
    task automatic send_item(input logic mode, input logic [7:0] data,
                             input logic use_known, input logic [159:0] known_digest);
        logic [159:0] predicted;
        if (!calm && $urandom_range(0, 99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.mode      <= mode;
        in_ch.data_byte <= data;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        if (predict_digest(mode, data, predicted)) begin
            if (use_known)
                predicted = known_digest;
            for (int i = 0; i < CHAIN_WORDS; i++)
                digest_q.push_back('{predicted[159-32*i -: 32], 3'(i), i == CHAIN_WORDS-1});
        end
        items_sent++;
        if (items_sent >= CALM_FROM)
            calm = 1'b1;
        @(negedge i_clk);
    endtask

    // one message of random bytes followed by a finish
    task automatic send_message(input int unsigned len);
        idle_pct  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
        for (int unsigned n = 0; n < len; n++)
            send_item(MODE_ABSORB, 8'($urandom_range(0, 255)), 1'b0, '0);
        send_item(MODE_FINISH, 8'($urandom_range(0, 255)), 1'b0, '0);
    endtask

    function automatic int unsigned pick_length();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 3) begin
            // lengths around the padding and block boundaries
            case ($urandom_range(0, 11))
                0:       return 0;
                1:       return 1;
                2:       return 55;
                3:       return 56;
                4:       return 57;
                5:       return 63;
                6:       return 64;
                7:       return 65;
                8:       return 119;
                9:       return 120;
                10:      return 127;
                default: return 128;
            endcase
        end
        if (sel == 3)
            return $urandom_range(100, 140);
        return $urandom_range(0, 24);
    endfunction

    // stimulus and end of run
    initial begin
        int unsigned len;
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.mode       <= MODE_ABSORB;
        in_ch.data_byte  <= 8'h00;
        out_ch.ready     <= 1'b0;
        mismatches       = 0;
        items_sent       = 0;
        idle_pct         = 30;
        stall_pct        = 30;
        calm             = 1'b0;
        hold_req         = 1'b0;
        restart_message();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int r = 0; r < DIRECTED_COUNT; r++)
            send_item(DIRECTED_ROWS[r].mode, DIRECTED_ROWS[r].data,
                      DIRECTED_ROWS[r].known, DIRECTED_ROWS[r].digest);

        // long output hold-off while short messages keep coming
        hold_req = 1'b1;
        for (int m = 0; m < 4; m++)
            send_message($urandom_range(0, 4));

        // random messages, the last one cut so the run ends near the item total
        while (items_sent < TOTAL_ITEMS) begin
            len = pick_length();
            if (items_sent + len + 1 > TOTAL_ITEMS)
                len = TOTAL_ITEMS - items_sent - 1;
            send_message(len);
        end
        in_ch.valid <= 1'b0;

        while (digest_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // output side: random stall bursts and one long hold-off
    initial begin
        int unsigned stall_left;
        int unsigned hold_left;
        logic        rdy;
        stall_left = 0;
        hold_left  = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                rdy = 1'b0;
            end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(1, 6) - 1;
                rdy        = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            out_ch.ready <= rdy;
        end
    end

    // digest word checker
    initial begin
        t_digest_word exp_w;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                if (digest_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected digest word %h index %0d",
                                              out_ch.digest_word, out_ch.word_index));
                end else begin
                    exp_w = digest_q.pop_front();
                    if (out_ch.digest_word !== exp_w.word)
                        report_mismatch($sformatf("digest_word %h, expected %h",
                                                  out_ch.digest_word, exp_w.word));
                    if (out_ch.word_index !== exp_w.idx)
                        report_mismatch($sformatf("word_index %0d, expected %0d",
                                                  out_ch.word_index, exp_w.idx));
                    if (out_ch.last_word !== exp_w.last)
                        report_mismatch($sformatf("last_word %b, expected %b",
                                                  out_ch.last_word, exp_w.last));
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/sha1_pkg.sv
rtl/core/sha1_if.sv
rtl/core/sha1_ram.sv
rtl/core/sha1_sched.sv
rtl/core/sha1_round.sv
rtl/core/sha1_hash_engine.sv
rtl/core/sha1_checker.sv
sim/tb_sha1_hash_engine.sv
